### rtl/lcn_pkg.sv
// Shared types, constants and the orientation table of the LED cube node decoder.
`timescale 1ns / 1ps
`default_nettype none
package lcn_pkg;

  localparam int IDX_W       = 18;
  localparam int DIM_REG_W   = 7;
  localparam int COORD_OUT_W = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_DIM_DEF = 64;
  localparam int NUM_CUBE_STYLES = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_DEPTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CORNER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_STYLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND_STYLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND_LAYER = 3'd6;

  // Strand styles.
  localparam logic [1:0] STRAND_ZIGZAG   = 2'd0;
  localparam logic [1:0] STRAND_STRAIGHT = 2'd1;
  localparam logic [1:0] STRAND_ALT      = 2'd2;

  // Quarter-turn codes: none, one positive, two, one negative.
  localparam logic [1:0] T0 = 2'd0;
  localparam logic [1:0] TP = 2'd1;
  localparam logic [1:0] T2 = 2'd2;
  localparam logic [1:0] TN = 2'd3;

  // Per entry: x turns, y turns, z turns, x mirror. Index is corner * 6 + style.
  localparam logic [6:0] XFORM_TABLE [48] = '{
    {TP,T0,TN,1'b0}, {T0,T0,TN,1'b1}, {T0,TN,T0,1'b1},
    {T0,T0,T0,1'b0}, {TN,T2,T0,1'b1}, {TN,TN,T0,1'b0},
    {TP,T0,TN,1'b1}, {T0,T0,TN,1'b0}, {T0,TN,T0,1'b0},
    {T0,T0,T0,1'b1}, {TN,T2,T0,1'b0}, {TN,TN,T0,1'b1},
    {TP,T0,TP,1'b1}, {T0,T0,TP,1'b0}, {T0,TN,T2,1'b0},
    {T0,T0,T2,1'b1}, {TN,T2,T2,1'b0}, {TN,TN,T2,1'b1},
    {TP,T0,TP,1'b0}, {T0,T0,TP,1'b1}, {T0,TN,T2,1'b1},
    {T0,T0,T2,1'b0}, {TN,T2,T2,1'b1}, {TN,TN,T2,1'b0},
    {TN,T0,TN,1'b1}, {T0,T2,TP,1'b0}, {T0,TP,T0,1'b0},
    {T0,T2,T0,1'b1}, {TN,T0,T0,1'b0}, {TN,TP,T0,1'b1},
    {TN,T0,TN,1'b0}, {T0,T2,TP,1'b1}, {T0,TP,T0,1'b1},
    {T0,T2,T0,1'b0}, {TN,T0,T0,1'b1}, {TN,TP,T0,1'b0},
    {TN,T0,TP,1'b0}, {T0,T2,TN,1'b1}, {T0,TN,T2,1'b0},
    {T2,T0,T0,1'b0}, {TN,T2,T2,1'b0}, {TP,TN,T0,1'b0},
    {TN,T0,TP,1'b1}, {T0,T2,TN,1'b0}, {T0,TN,T2,1'b1},
    {T2,T0,T0,1'b1}, {TN,T2,T2,1'b1}, {TP,TN,T0,1'b1}
  };

  // Static controls for the mapping stages.
  typedef struct packed {
    logic [1:0] xr;
    logic [1:0] yr;
    logic [1:0] zr;
    logic       mirror;
    logic [1:0] sstyle;
    logic       per_layer;
  } map_ctrl_t;

endpackage
`default_nettype wire

### rtl/led_cube_node_to_coordinate_unit.sv
// Top level of the LED cube node-to-voxel decoder.
`timescale 1ns / 1ps
`default_nettype none
// Pipeline from the accepting edge to done_o: three entry stages, two dividers of one
// quotient bit per stage and four map stages.
// Throughput: one word per cycle; busy_o stays low and the receiver cannot stall.
// Reset: asynchronous, active low; dimensions return to 1, other configuration registers to 0, and all
// pipeline valid bits clear.
module led_cube_node_to_coordinate_unit import lcn_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [IDX_W-1:0]       node_index_i,
  output logic                        done_o,
  output logic [COORD_OUT_W-1:0]      voxel_x_o,
  output logic [COORD_OUT_W-1:0]      voxel_y_o,
  output logic [COORD_OUT_W-1:0]      voxel_z_o,
  output logic                        index_out_of_range_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [DIM_REG_W-1:0]   cfg_data_i
);

  localparam int QW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);

  // Configuration registers.
  logic [DIM_REG_W-1:0] cube_width_q, cube_height_q, cube_depth_q;
  logic [2:0]           start_corner_q, cube_style_q;
  logic [1:0]           strand_style_q;
  logic                 strand_layer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_width_q   <= DIM_REG_W'(1);
      cube_height_q  <= DIM_REG_W'(1);
      cube_depth_q   <= DIM_REG_W'(1);
      start_corner_q <= '0;
      cube_style_q   <= '0;
      strand_style_q <= '0;
      strand_layer_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CUBE_WIDTH:   cube_width_q   <= cfg_data_i;
        REG_CUBE_HEIGHT:  cube_height_q  <= cfg_data_i;
        REG_CUBE_DEPTH:   cube_depth_q   <= cfg_data_i;
        REG_START_CORNER: start_corner_q <= cfg_data_i[2:0];
        REG_CUBE_STYLE:   cube_style_q   <= cfg_data_i[2:0];
        REG_STRAND_STYLE: strand_style_q <= cfg_data_i[1:0];
        REG_STRAND_LAYER: strand_layer_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Dimensions are clamped to 1..MAX_DIM before any use.
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  // The user must keep the configuration static while words are in flight; the block
  // does not enforce this. Everything derived from it is computed once here and
  // registered, and words read the range total no earlier than the map stage.
  logic [DW-1:0] w0, h0, d0, w1, h1, d1, h2, d2, w3, w4;
  logic [2:0]    style;
  logic [6:0]    entry;
  logic          xq, yq, zq;
  map_ctrl_t     ctrl_d;

  always_comb begin
    w0 = clamp_dim(cube_width_q);
    h0 = clamp_dim(cube_height_q);
    d0 = clamp_dim(cube_depth_q);
    style = (int'(cube_style_q) >= NUM_CUBE_STYLES) ? 3'd0 : cube_style_q;
    entry = XFORM_TABLE[6'(6'(start_corner_q) * 6'd6 + 6'(style))];
    ctrl_d.xr = entry[6:5];
    ctrl_d.yr = entry[4:3];
    ctrl_d.zr = entry[2:1];
    ctrl_d.mirror = entry[0];
    ctrl_d.sstyle = (strand_style_q == 2'd3) ? STRAND_ZIGZAG : strand_style_q;
    ctrl_d.per_layer = strand_layer_q;
    // A single quarter turn about an axis swaps the other two extents.
    xq = (ctrl_d.xr == TP) || (ctrl_d.xr == TN);
    yq = (ctrl_d.yr == TP) || (ctrl_d.yr == TN);
    zq = (ctrl_d.zr == TP) || (ctrl_d.zr == TN);
    // Pre-swap to undo the later rotations.
    w1 = zq ? h0 : w0;
    h1 = zq ? w0 : h0;
    d1 = d0;
    if (yq) begin
      d1 = w1;
      w1 = d0;
    end
    if (xq) begin
      h2 = d1;
      d2 = h1;
      d1 = h1;
      h1 = h2;
    end
    // Extents as the rotation stages see them.
    h2 = xq ? d1 : h1;
    d2 = xq ? h1 : d1;
    w3 = yq ? d2 : w1;
    w4 = zq ? h2 : w3;
  end

  logic [DW-1:0]   w0_q, h0_q, d0_q, w1_q, h1_q, d1_q, h2_q, d2_q, w3_q, w4_q;
  map_ctrl_t       ctrl_q;
  logic [2*DW-1:0] lsize_q, wh0_q;
  logic [DW-1:0]   d0b_q;
  logic [3*DW-1:0] total_q;

  always_ff @(posedge clk_i) begin
    w0_q    <= w0;
    h0_q    <= h0;
    d0_q    <= d0;
    w1_q    <= w1;
    h1_q    <= h1;
    d1_q    <= d1;
    h2_q    <= h2;
    d2_q    <= d2;
    w3_q    <= w3;
    w4_q    <= w4;
    ctrl_q  <= ctrl_d;
    lsize_q <= (2*DW)'(w1_q) * (2*DW)'(h1_q);
    wh0_q   <= (2*DW)'(w0_q) * (2*DW)'(h0_q);
    d0b_q   <= d0_q;
    total_q <= (3*DW)'(wh0_q) * (3*DW)'(d0b_q);
  end

  // Entry stages.
  logic             v0_q, v1_q, v2_q;
  logic [IDX_W-1:0] i0_q, i1_q, i2_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q <= node_index_i;
    i1_q <= i0_q;
    i2_q <= i1_q;
  end

  // Layer = index / layer size; the remainder is the offset in the layer.
  logic             dv1_valid;
  logic [QW-1:0]    dv1_quo;
  logic [IDX_W-1:0] dv1_rem;
  logic [IDX_W-1:0] dv1_pay;

  lcn_div_pipe #(
    .QW   (QW),
    .NW   (IDX_W),
    .DENW (2*DW),
    .PW   (IDX_W)
  ) u_div_layer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .num_i   (i2_q),
    .den_i   (lsize_q),
    .pay_i   (i2_q),
    .valid_o (dv1_valid),
    .quo_o   (dv1_quo),
    .rem_o   (dv1_rem),
    .pay_o   (dv1_pay)
  );

  // Row = offset / width; the remainder is the column.
  logic                dv2_valid;
  logic [QW-1:0]       dv2_quo;
  logic [IDX_W-1:0]    dv2_rem;
  logic [IDX_W+QW-1:0] dv2_pay;

  lcn_div_pipe #(
    .QW   (QW),
    .NW   (IDX_W),
    .DENW (DW),
    .PW   (IDX_W + QW)
  ) u_div_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv1_valid),
    .num_i   (dv1_rem),
    .den_i   (w1_q),
    .pay_i   ({dv1_pay, dv1_quo}),
    .valid_o (dv2_valid),
    .quo_o   (dv2_quo),
    .rem_o   (dv2_rem),
    .pay_o   (dv2_pay)
  );

  logic [QW-1:0] map_x, map_y, map_z;

  lcn_map #(
    .MAX_DIM (MAX_DIM)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv2_valid),
    .idx_i   (dv2_pay[IDX_W+QW-1:QW]),
    .z_i     (dv2_pay[QW-1:0]),
    .y_i     (dv2_quo),
    .col_i   (dv2_rem[QW-1:0]),
    .total_i (total_q),
    .w1_i    (w1_q),
    .h1_i    (h1_q),
    .d1_i    (d1_q),
    .h2_i    (h2_q),
    .d2_i    (d2_q),
    .w3_i    (w3_q),
    .w4_i    (w4_q),
    .ctrl_i  (ctrl_q),
    .valid_o (done_o),
    .x_o     (map_x),
    .y_o     (map_y),
    .z_o     (map_z),
    .oor_o   (index_out_of_range_o)
  );

  // Coordinates leave masked to the port width.
  assign voxel_x_o = COORD_OUT_W'(map_x);
  assign voxel_y_o = COORD_OUT_W'(map_y);
  assign voxel_z_o = COORD_OUT_W'(map_z);

endmodule
`default_nettype wire

### rtl/lcn_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module lcn_div_pipe #(
  parameter int QW   = 6,
  parameter int NW   = 18,
  parameter int DENW = 14,
  parameter int PW   = 18
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [NW-1:0]   num_i,
  input  wire logic [DENW-1:0] den_i,
  input  wire logic [PW-1:0]   pay_i,
  output logic                 valid_o,
  output logic [QW-1:0]        quo_o,
  output logic [NW-1:0]        rem_o,
  output logic [PW-1:0]        pay_o
);

  localparam int CW = (NW > DENW + QW) ? NW : DENW + QW;

  logic          vld_q [QW];
  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [PW-1:0] pay_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int SH = QW - 1 - i;
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [PW-1:0] pay_in;
    logic [CW-1:0] rem_ext;
    logic [CW-1:0] den_sh;
    logic          fits;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (i == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    always_comb begin
      rem_ext = CW'(rem_in);
      den_sh  = CW'(den_i) << SH;
      fits    = (rem_ext >= den_sh);
      rem_d   = fits ? NW'(rem_ext - den_sh) : rem_in;
      quo_d   = fits ? (quo_in | (QW'(1) << SH)) : quo_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      quo_q[i] <= quo_d;
      pay_q[i] <= pay_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule
`default_nettype wire

### rtl/lcn_map.sv
// Strand decode, layer reversal, three rotation stages and the final mirror.
`timescale 1ns / 1ps
`default_nettype none
module lcn_map import lcn_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [IDX_W-1:0]              idx_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]    z_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]    y_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]    col_i,
  input  wire logic [3*$clog2(MAX_DIM+1)-1:0] total_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  w1_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  h1_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  d1_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  h2_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  d2_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  w3_i,
  input  wire logic [$clog2(MAX_DIM+1)-1:0]  w4_i,
  input  wire map_ctrl_t                     ctrl_i,
  output logic                               valid_o,
  output logic [$clog2(MAX_DIM)-1:0]         x_o,
  output logic [$clog2(MAX_DIM)-1:0]         y_o,
  output logic [$clog2(MAX_DIM)-1:0]         z_o,
  output logic                               oor_o
);

  localparam int QW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int TW = 3 * DW;
  localparam int EW = (TW > IDX_W) ? TW : IDX_W;

  // One rotation of the pair (a, b) inside extents (ea, eb).
  function automatic logic [2*QW-1:0] turn(input logic [QW-1:0] a, input logic [QW-1:0] b,
                                           input logic [1:0] code, input logic first,
                                           input logic [DW-1:0] ea, input logic [DW-1:0] eb);
    logic [DW-1:0] na;
    logic [DW-1:0] nb;
    unique case (code)
      T0: begin
        na = DW'(a);
        nb = DW'(b);
      end
      T2: begin
        na = ea - DW'(a) - DW'(1);
        nb = eb - DW'(b) - DW'(1);
      end
      default: begin
        if (first) begin
          na = eb - DW'(b) - DW'(1);
          nb = DW'(a);
        end else begin
          na = DW'(b);
          nb = ea - DW'(a) - DW'(1);
        end
      end
    endcase
    return {QW'(na), QW'(nb)};
  endfunction

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          o1_q, o2_q, o3_q;
  logic [QW-1:0] x1_q, y1_q, z1_q;
  logic [QW-1:0] x2_q, y2_q, z2_q;
  logic [QW-1:0] x3_q, y3_q, z3_q;
  logic [QW-1:0] x4_q, y4_q, z4_q;
  logic          o4_q;

  // Stage one: column to x along the strand, reversal of odd layers, range flag.
  logic [DW:0]   colw, half, xa;
  logic [QW-1:0] x1_d, y1_d;
  logic          o1_d;

  always_comb begin
    colw = (DW+1)'(col_i);
    half = ((DW+1)'(w1_i) + (DW+1)'(1)) >> 1;
    if (ctrl_i.sstyle == STRAND_ALT) begin
      if (colw + (DW+1)'(1) <= half) begin
        xa = colw << 1;
      end else begin
        xa = (((DW+1)'(w1_i) - colw - (DW+1)'(1)) << 1) + (DW+1)'(1);
      end
    end else if (ctrl_i.sstyle == STRAND_STRAIGHT || !y_i[0]) begin
      xa = colw;
    end else begin
      xa = (DW+1)'(w1_i) - colw - (DW+1)'(1);
    end
    x1_d = QW'(xa);
    y1_d = y_i;
    if (!ctrl_i.per_layer && z_i[0]) begin
      y1_d = QW'(h1_i - DW'(y_i) - DW'(1));
      if (h1_i[0] && ctrl_i.sstyle == STRAND_ZIGZAG) begin
        x1_d = QW'(w1_i - DW'(x1_d) - DW'(1));
      end
    end
    o1_d = (EW'(idx_i) >= EW'(total_i));
  end

  logic [2*QW-1:0] rx, ry, rz;
  logic [QW-1:0]   x4_d;

  always_comb begin
    rx = turn(y1_q, z1_q, ctrl_i.xr, ctrl_i.xr == TP, h1_i, d1_i);
    ry = turn(x2_q, z2_q, ctrl_i.yr, ctrl_i.yr == TN, w1_i, d2_i);
    rz = turn(x3_q, y3_q, ctrl_i.zr, ctrl_i.zr == TN, w3_i, h2_i);
    x4_d = rz[2*QW-1:QW];
    if (ctrl_i.mirror) begin
      x4_d = QW'(w4_i - DW'(rz[2*QW-1:QW]) - DW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d;
    y1_q <= y1_d;
    z1_q <= z_i;
    o1_q <= o1_d;
    x2_q <= x1_q;
    y2_q <= rx[2*QW-1:QW];
    z2_q <= rx[QW-1:0];
    o2_q <= o1_q;
    x3_q <= ry[2*QW-1:QW];
    y3_q <= y2_q;
    z3_q <= ry[QW-1:0];
    o3_q <= o2_q;
    // Out-of-range words report the origin.
    x4_q <= o3_q ? '0 : x4_d;
    y4_q <= o3_q ? '0 : rz[QW-1:0];
    z4_q <= o3_q ? '0 : z3_q;
    o4_q <= o3_q;
  end

  assign valid_o = v4_q;
  assign x_o     = x4_q;
  assign y_o     = y4_q;
  assign z_o     = z4_q;
  assign oor_o   = o4_q;

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the LED cube node-to-voxel decoder.
`timescale 1ns / 1ps
module tb_top;
  import lcn_pkg::*;

  localparam int LATENCY = 2 * $clog2(MAX_DIM_DEF) + 6;
  localparam int DIR_ROWS = 22;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] x;
    logic [COORD_OUT_W-1:0] y;
    logic [COORD_OUT_W-1:0] z;
    logic                   oor;
  } voxel_t;

  // One directed row: a full configuration, an index, and optionally a typed-in answer.
  typedef struct {
    int     w, h, d, corner, cstyle, sstyle, per_layer;
    int     idx;
    bit     typed;
    voxel_t answer;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] node_index = '0;
  logic done;
  logic [COORD_OUT_W-1:0] vx, vy, vz;
  logic oor;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DIM_REG_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  int unsigned sh_w = 1, sh_h = 1, sh_d = 1, sh_corner = 0, sh_cstyle = 0;
  int unsigned sh_sstyle = 0, sh_layer = 0;

  voxel_t pending_voxels[$];
  int fails = 0;
  int send_idle_pct = 0;

  always #5 clk = ~clk;

  led_cube_node_to_coordinate_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .node_index_i(node_index), .done_o(done),
    .voxel_x_o(vx), .voxel_y_o(vy), .voxel_z_o(vz),
    .index_out_of_range_o(oor),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // Turn code of the orientation table as a signed count.
  function automatic int turn_val(logic [1:0] c);
    case (c)
      TP:      return 1;
      T2:      return 2;
      TN:      return -1;
      default: return 0;
    endcase
  endfunction

  // Rotates the pair (a,b) by quarter turns; the extents swap with each turn.
  function automatic void rotate_pair(inout int a, inout int b, input int n,
                                      input bit first_form, input int ea, input int eb);
    int na, nb, t;
    for (int i = 0; i < n; i++) begin
      if (first_form) begin
        na = eb - b - 1;
        nb = a;
      end else begin
        na = b;
        nb = ea - a - 1;
      end
      a = na;
      b = nb;
      t = ea; ea = eb; eb = t;
    end
  endfunction

  function automatic int fit_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  // Computes the voxel that a wiring position lands on under the shadow configuration.
  function automatic voxel_t locate_voxel(int unsigned idx);
    voxel_t v;
    logic [6:0] ent;
    int w, h, d, t, x, y, z, col, xr, yr, zr, pos, lsz, base;
    int unsigned cs, ss;
    w = fit_dim(sh_w);
    h = fit_dim(sh_h);
    d = fit_dim(sh_d);
    cs = (sh_cstyle > 5) ? 0 : sh_cstyle;
    ss = (sh_sstyle > 2) ? 0 : sh_sstyle;
    ent = XFORM_TABLE[sh_corner * 6 + cs];
    xr = turn_val(ent[6:5]);
    yr = turn_val(ent[4:3]);
    zr = turn_val(ent[2:1]);
    v = '0;
    if (idx >= w * h * d) begin
      v.oor = 1'b1;
      return v;
    end
    if (zr == 1 || zr == -1) begin t = w; w = h; h = t; end
    if (yr == 1 || yr == -1) begin t = w; w = d; d = t; end
    if (xr == 1 || xr == -1) begin t = h; h = d; d = t; end
    lsz = w * h;
    z = idx / lsz;
    base = idx % lsz;
    y = base / w;
    col = base % w;
    if (ss == STRAND_ALT) begin
      pos = col + 1;
      x = (pos <= (w + 1) / 2) ? 2 * (pos - 1) : (w - pos) * 2 + 1;
    end else if (ss == STRAND_STRAIGHT || y[0] == 1'b0) begin
      x = col;
    end else begin
      x = w - col - 1;
    end
    if (sh_layer == 0 && z[0]) begin
      y = h - y - 1;
      if (h[0] && ss == STRAND_ZIGZAG) x = w - x - 1;
    end
    rotate_pair(y, z, (xr < 0) ? -xr : xr, xr > 0, h, d);
    if (xr == 1 || xr == -1) begin t = h; h = d; d = t; end
    rotate_pair(x, z, (yr < 0) ? -yr : yr, yr < 0, w, d);
    if (yr == 1 || yr == -1) begin t = w; w = d; d = t; end
    rotate_pair(x, y, (zr < 0) ? -zr : zr, zr < 0, w, h);
    if (zr == 1 || zr == -1) begin t = w; w = h; h = t; end
    if (ent[0]) x = w - x - 1;
    v.x = x[5:0];
    v.y = y[5:0];
    v.z = z[5:0];
    return v;
  endfunction

  // Checks every result word against the oldest expected voxel.
  always @(posedge clk) begin
    voxel_t got, exp_v;
    if (rst_n && done) begin
      got = '{x: vx, y: vy, z: vz, oor: oor};
      if (pending_voxels.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d oor=%0d", $time, vx, vy, vz, oor);
        fails++;
      end else begin
        exp_v = pending_voxels.pop_front();
        if (got.x !== exp_v.x)
          $display("%0t: voxel_x expected %0d actual %0d", $time, exp_v.x, got.x);
        if (got.y !== exp_v.y)
          $display("%0t: voxel_y expected %0d actual %0d", $time, exp_v.y, got.y);
        if (got.z !== exp_v.z)
          $display("%0t: voxel_z expected %0d actual %0d", $time, exp_v.z, got.z);
        if (got.oor !== exp_v.oor)
          $display("%0t: index_out_of_range expected %0d actual %0d", $time, exp_v.oor,
                   got.oor);
        if (got !== exp_v) fails++;
      end
    end
  end

  // Waits until all expected words have come, then lets the pipeline drain.
  task automatic drain_pipe();
    while (pending_voxels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] r, int unsigned val);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= val[DIM_REG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_CUBE_WIDTH:   sh_w = val & 7'h7f;
      REG_CUBE_HEIGHT:  sh_h = val & 7'h7f;
      REG_CUBE_DEPTH:   sh_d = val & 7'h7f;
      REG_START_CORNER: sh_corner = val & 3'h7;
      REG_CUBE_STYLE:   sh_cstyle = val & 3'h7;
      REG_STRAND_STYLE: sh_sstyle = val & 2'h3;
      default:          sh_layer = val & 1'h1;
    endcase
  endtask

  // Block must be idle before this is called.
  task automatic load_config(int w, int h, int d, int corner, int cs, int ss, int pl);
    write_reg(REG_CUBE_WIDTH, w);
    write_reg(REG_CUBE_HEIGHT, h);
    write_reg(REG_CUBE_DEPTH, d);
    write_reg(REG_START_CORNER, corner);
    write_reg(REG_CUBE_STYLE, cs);
    write_reg(REG_STRAND_STYLE, ss);
    write_reg(REG_STRAND_LAYER, pl);
  endtask

  // Presents one word; start stays high across back-to-back words.
  task automatic send_index(int unsigned idx, voxel_t exp_v);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    node_index <= idx[IDX_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_voxels = {pending_voxels, exp_v};
  endtask

  // Random dimension: mostly small, sometimes an extreme or out-of-range value.
  function automatic int pick_dim();
    case ($urandom_range(9))
      0:       return $urandom_range(127);
      1:       return MAX_DIM_DEF;
      2:       return 1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // The first index past the cube is only used where it fits the index port.
  function automatic int unsigned pick_index();
    int unsigned vol;
    vol = fit_dim(sh_w) * fit_dim(sh_h) * fit_dim(sh_d);
    case ($urandom_range(9))
      0:       return $urandom_range((1 << IDX_W) - 1);
      1:       return vol - 1;
      2:       return (vol < (1 << IDX_W)) ? vol : vol - 1;
      default: return $urandom_range(vol - 1);
    endcase
  endfunction

  initial begin
    dir_row_t rows[DIR_ROWS];
    voxel_t exp_v;
    int phase_idle[3] = '{23, 49, 0};
    // Directed rows: extremes, every cube and strand style, odd layers, clamped codes.
    rows = '{
      '{1, 1, 1, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{1, 1, 1, 0, 0, 0, 0, 1, 1, '{0, 0, 0, 1}},
      '{1, 1, 1, 0, 0, 0, 0, 262143, 1, '{0, 0, 0, 1}},
      '{64, 64, 64, 3, 3, 0, 0, 262143, 0, '0},
      '{64, 64, 64, 3, 3, 0, 0, 262144 - 1 - 1, 0, '0},
      '{64, 64, 64, 3, 3, 1, 1, 0, 0, '0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{127, 127, 127, 7, 5, 2, 1, 262143, 0, '0},
      '{127, 127, 127, 7, 5, 2, 1, 262142, 0, '0},
      '{4, 3, 5, 0, 0, 0, 0, 17, 0, '0},
      '{4, 3, 5, 1, 1, 0, 0, 17, 0, '0},
      '{4, 3, 5, 2, 2, 1, 0, 29, 0, '0},
      '{4, 3, 5, 3, 3, 2, 0, 33, 0, '0},
      '{5, 3, 4, 4, 4, 0, 0, 22, 0, '0},
      '{5, 3, 4, 5, 5, 2, 1, 40, 0, '0},
      '{3, 3, 3, 6, 6, 3, 0, 13, 0, '0},
      '{3, 3, 3, 7, 7, 0, 0, 14, 0, '0},
      '{6, 5, 2, 6, 2, 2, 0, 59, 0, '0},
      '{7, 2, 3, 7, 1, 0, 1, 20, 0, '0},
      '{5, 5, 5, 2, 4, 0, 0, 124, 0, '0},
      '{5, 5, 5, 2, 4, 0, 0, 125, 1, '{0, 0, 0, 1}},
      '{8, 1, 1, 0, 3, 2, 0, 7, 0, '0}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reconfigure only when the row asks for a different setup.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 0 || rows[i].w != rows[i-1].w || rows[i].h != rows[i-1].h ||
          rows[i].d != rows[i-1].d || rows[i].corner != rows[i-1].corner ||
          rows[i].cstyle != rows[i-1].cstyle || rows[i].sstyle != rows[i-1].sstyle ||
          rows[i].per_layer != rows[i-1].per_layer) begin
        start <= 1'b0;
        drain_pipe();
        load_config(rows[i].w, rows[i].h, rows[i].d, rows[i].corner, rows[i].cstyle,
                    rows[i].sstyle, rows[i].per_layer);
      end
      exp_v = rows[i].typed ? rows[i].answer : locate_voxel(rows[i].idx);
      send_index(rows[i].idx, exp_v);
    end

    // Random part in three idling phases, a new configuration every 28 words.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = phase_idle[ph];
      for (int blk = 0; blk < 6; blk++) begin
        int unsigned idx;
        start <= 1'b0;
        drain_pipe();
        load_config(pick_dim(), pick_dim(), pick_dim(), $urandom_range(7),
                    $urandom_range(7), $urandom_range(3), $urandom_range(1));
        for (int k = 0; k < 28; k++) begin
          idx = pick_index();
          send_index(idx, locate_voxel(idx));
        end
      end
    end
    start <= 1'b0;
    drain_pipe();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
